FILE: rtl/core/qsd_pkg.sv
// Package for the scaled Q31 DFT: field widths, the sequencer state type
// and the quarter-wave Q2.30 twiddle table with its lookup functions.
// No dependencies.
package qsd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int ROM_LOG2       = 6;
  localparam int DATA_W         = 32;
  localparam int BIN_W          = 6;
  localparam int LOG2_W         = 3;
  localparam int TW_FRAC        = 30;
  // 64 terms of at most 2^62 each, plus sign.
  localparam int ACC_W          = 70;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // cos(2*pi*i/64) in Q2.30 for the first quarter wave.
  localparam logic signed [DATA_W-1:0] QUARTER_COS [17] = '{
    32'sd1073741824, 32'sd1068571464, 32'sd1053110176, 32'sd1027506862,
    32'sd992008094,  32'sd946955747,  32'sd892783698,  32'sd830013654,
    32'sd759250125,  32'sd681174602,  32'sd596538995,  32'sd506158392,
    32'sd410903207,  32'sd311690799,  32'sd209476638,  32'sd105245103,
    32'sd0
  };

  function automatic logic signed [DATA_W-1:0] tw_cos(input logic [ROM_LOG2-1:0] m);
    logic [4:0] fwd;
    logic [4:0] rev;
    logic signed [DATA_W-1:0] res;
    fwd = {1'b0, m[3:0]};
    rev = 5'd16 - fwd;
    case (m[5:4])
      2'd0:    res = QUARTER_COS[fwd];
      2'd1:    res = -QUARTER_COS[rev];
      2'd2:    res = -QUARTER_COS[fwd];
      default: res = QUARTER_COS[rev];
    endcase
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] tw_sin(input logic [ROM_LOG2-1:0] m);
    return tw_cos(m + 6'd48);
  endfunction

endpackage

FILE: rtl/core/q31_scaled_dft.sv
// Scaled direct DFT over complex Q31 samples, top level.
// Depends on qsd_pkg and qsd_ram.
//
// Samples are taken one per cycle while busy is low; a sample is transferred
// at an edge where start is high and busy is low. The N-th sample of a block
// (N = 2^log2_size, clamped to 1..log2(MAX_POINTS)) starts the transform and
// raises busy. A single complex multiply-accumulate unit, fed from the sample
// RAM and the twiddle table, processes one term per cycle while accumulating
// a bin, and the block stays busy until its last bin is emitted. Each bin is
// presented for exactly one cycle with bin_valid high and must be captured
// then, as there is no back-pressure.
// Writing log2_size discards any partial block.
module q31_scaled_dft
  #(parameter int MAX_POINTS = qsd_pkg::MAX_POINTS_DEF)
  (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qsd_pkg::DATA_W-1:0]   sample_re,
  input  logic signed [qsd_pkg::DATA_W-1:0]   sample_im,
  input  logic                                log2_size_wr,
  input  logic [qsd_pkg::LOG2_W-1:0]          log2_size,
  output logic                                bin_valid,
  output logic signed [qsd_pkg::DATA_W-1:0]   bin_re,
  output logic signed [qsd_pkg::DATA_W-1:0]   bin_im,
  output logic [qsd_pkg::BIN_W-1:0]           bin_index,
  output logic                                last_bin
);

  import qsd_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [LOG2_W-1:0] LIM = LOG2_W'(AW);

  state_t state;
  state_t state_next;

  logic [LOG2_W-1:0] log2_reg;
  logic [LOG2_W-1:0] l_eff;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     count;
  logic [AW-1:0]     k_idx;
  logic [AW-1:0]     n_idx;
  logic [ROM_LOG2-1:0] phase;
  logic [ROM_LOG2-1:0] step;
  logic [6:0]        shamt;
  logic [ACC_W-1:0]  round_mask;

  logic                     v1;
  logic                     v2;
  logic                     wr_en;
  logic [2*DATA_W-1:0]      rd_data;
  logic signed [DATA_W-1:0] xr;
  logic signed [DATA_W-1:0] xi;
  logic signed [DATA_W-1:0] cos_q;
  logic signed [DATA_W-1:0] sin_q;
  logic signed [2*DATA_W-1:0] p_rc;
  logic signed [2*DATA_W-1:0] p_is;
  logic signed [2*DATA_W-1:0] p_ic;
  logic signed [2*DATA_W-1:0] p_rs;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [ACC_W-1:0]  rnd_re;
  logic signed [ACC_W-1:0]  rnd_im;
  logic signed [ACC_W-1:0]  sh_re;
  logic signed [ACC_W-1:0]  sh_im;

  function automatic logic signed [DATA_W-1:0] sat_q31(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    logic signed [DATA_W-1:0] res;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      res = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [ACC_W-1:0] sext_prod(input logic signed [2*DATA_W-1:0] p);
    return {{(ACC_W-2*DATA_W){p[2*DATA_W-1]}}, p};
  endfunction

  // Effective length exponent, clamped to the supported range.
  always_comb begin
    if (log2_reg == '0) begin
      l_eff = LOG2_W'(1);
    end else if (log2_reg > LIM) begin
      l_eff = LIM;
    end else begin
      l_eff = log2_reg;
    end
  end

  assign last_idx   = AW'((7'd1 << l_eff) - 7'd1);
  assign step       = ROM_LOG2'(ROM_LOG2'(n_idx) << (LOG2_W'(ROM_LOG2) - l_eff));
  assign shamt      = 7'(TW_FRAC) + 7'(l_eff);
  assign round_mask = ~({ACC_W{1'b1}} << shamt);
  assign xr         = rd_data[DATA_W-1:0];
  assign xi         = rd_data[2*DATA_W-1:DATA_W];
  assign sh_re      = rnd_re >>> shamt;
  assign sh_im      = rnd_im >>> shamt;
  assign wr_en      = (state == ST_LOAD) && start;

  qsd_ram #(
    .WIDTH (2*DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count),
    .wdata ({sample_im, sample_re}),
    .raddr (k_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        if (start && (count == last_idx)) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_idx == last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The accumulator is complete once both pipeline stages are empty.
        if (!v1 && !v2) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = (n_idx == last_idx) ? ST_LOAD : ST_MAC;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_reg  <= LOG2_RESET;
      count     <= '0;
      k_idx     <= '0;
      n_idx     <= '0;
      phase     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      bin_valid <= 1'b0;
    end else begin
      v1        <= (state == ST_MAC);
      v2        <= v1;
      bin_valid <= (state == ST_EMIT);
      if (log2_size_wr) begin
        log2_reg <= log2_size;
        count    <= '0;
      end else if (wr_en) begin
        count <= (count == last_idx) ? '0 : count + AW'(1);
      end
      case (state)
        ST_LOAD: begin
          k_idx <= '0;
          n_idx <= '0;
          phase <= '0;
        end
        ST_MAC: begin
          k_idx <= (k_idx == last_idx) ? '0 : k_idx + AW'(1);
          phase <= phase + step;
        end
        ST_EMIT: begin
          n_idx <= n_idx + AW'(1);
          k_idx <= '0;
          phase <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Shared complex multiply-accumulate datapath, output rounding and saturation.
  always_ff @(posedge clk) begin
    cos_q <= tw_cos(phase);
    sin_q <= tw_sin(phase);
    p_rc  <= xr * cos_q;
    p_is  <= xi * sin_q;
    p_ic  <= xi * cos_q;
    p_rs  <= xr * sin_q;
    if ((state == ST_MAC) && (k_idx == '0)) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + sext_prod(p_rc) + sext_prod(p_is);
      acc_im <= acc_im + sext_prod(p_ic) - sext_prod(p_rs);
    end
    // Biasing a negative sum before the arithmetic shift truncates towards zero.
    if (state == ST_ROUND) begin
      rnd_re <= acc_re + (acc_re[ACC_W-1] ? round_mask : '0);
      rnd_im <= acc_im + (acc_im[ACC_W-1] ? round_mask : '0);
    end
    if (state == ST_EMIT) begin
      bin_re    <= sat_q31(sh_re);
      bin_im    <= sat_q31(sh_im);
      bin_index <= BIN_W'(n_idx);
      last_bin  <= (n_idx == last_idx);
    end
  end

endmodule

FILE: rtl/core/qsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for q31_scaled_dft: drives complex Q31 sample blocks
// of every length, predicts each scaled bin and checks it on the strobe.
// Depends on qsd_pkg and the q31_scaled_dft RTL.
module testbench;
  import qsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [DATA_W-1:0] Q31_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q31_MIN = 32'sh8000_0000;
  localparam int PHASES = 14;
  localparam logic [LOG2_W-1:0] PHASE_LENGTH [PHASES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3, 3'd1, 3'd4, 3'd5, 3'd2
  };
  localparam int IDLE_MIX [4] = '{0, 53, 0, 27};

  // Holds the samples of the block being loaded and the bins still to arrive.
  class spectrum_scoreboard;
    typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [5:0]         index;
      logic               last;
    } bin_t;

    bin_t               pending_bins[$];
    logic signed [31:0] held_re[64];
    logic signed [31:0] held_im[64];
    int unsigned        held;
    int unsigned        length_log2;
    longint             quarter_wave[17];
    int                 mismatches;
    int                 bins_seen;
    int                 transforms;
    int                 discarded;

    function new();
      quarter_wave = '{
        1073741824, 1068571464, 1053110176, 1027506862,
        992008094,  946955747,  892783698,  830013654,
        759250125,  681174602,  596538995,  506158392,
        410903207,  311690799,  209476638,  105245103,
        0
      };
      length_log2 = 6;
      held        = 0;
      mismatches  = 0;
      bins_seen   = 0;
      transforms  = 0;
      discarded   = 0;
    endfunction

    // A length write clamps the exponent and throws away any partial block.
    function void set_length(logic [2:0] value);
      discarded   += held;
      held        = 0;
      length_log2 = (value == 0) ? 1 : (value > 6) ? 6 : value;
    endfunction

    function longint cos_q30(int unsigned m);
      int unsigned r;
      longint      v;
      m = m & 63;
      r = m & 15;
      case (m >> 4)
        0: begin
          v = quarter_wave[r];
        end
        1: begin
          v = -quarter_wave[16 - r];
        end
        2: begin
          v = -quarter_wave[r];
        end
        default: begin
          v = quarter_wave[16 - r];
        end
      endcase
      return v;
    endfunction

    // Shift right, truncate toward zero and saturate to Q31.
    function logic signed [31:0] scale_to_q31(logic signed [127:0] sum, int unsigned shift);
      logic [127:0] mag;
      mag = (sum < 0) ? -sum : sum;
      mag = mag >> shift;
      if (sum < 0) begin
        if (mag > 128'h8000_0000) return 32'sh8000_0000;
        return -mag[31:0];
      end
      if (mag > 128'h7fff_ffff) return 32'sh7fff_ffff;
      return mag[31:0];
    endfunction

    function void transform();
      int unsigned        pts;
      int unsigned        n;
      int unsigned        k;
      int unsigned        m;
      longint             xr;
      longint             xi;
      longint             c;
      longint             s;
      logic signed [127:0] acc_re;
      logic signed [127:0] acc_im;
      bin_t               b;
      pts = 1 << length_log2;
      for (n = 0; n < pts; n++) begin
        acc_re = 0;
        acc_im = 0;
        for (k = 0; k < pts; k++) begin
          m  = ((k * n) & (pts - 1)) << (6 - length_log2);
          c  = cos_q30(m);
          s  = cos_q30(m + 48);
          xr = held_re[k];
          xi = held_im[k];
          acc_re += xr * c;
          acc_re += xi * s;
          acc_im += xi * c;
          acc_im -= xr * s;
        end
        b.re    = scale_to_q31(acc_re, 30 + length_log2);
        b.im    = scale_to_q31(acc_im, 30 + length_log2);
        b.index = 6'(n);
        b.last  = (n == pts - 1);
        pending_bins.push_back(b);
      end
      transforms++;
    endfunction

    function void note_sample(logic signed [31:0] re, logic signed [31:0] im);
      held_re[held] = re;
      held_im[held] = im;
      held++;
      if (held == (1 << length_log2)) begin
        held = 0;
        transform();
      end
    endfunction

    function void check_bin(logic signed [31:0] re, logic signed [31:0] im,
                            logic [5:0] index, logic last);
      bin_t want;
      bins_seen++;
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: bin %0d arrived with none expected", index);
        return;
      end
      want = pending_bins.pop_front();
      if (re !== want.re || im !== want.im || index !== want.index || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected re %h im %h index %0d last %b", want.re, want.im,
                   want.index, want.last);
          $display("       actual   re %h im %h index %0d last %b", re, im, index, last);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] sample_re;
  logic signed [DATA_W-1:0] sample_im;
  logic                     log2_size_wr;
  logic [LOG2_W-1:0]        log2_size;
  logic                     bin_valid;
  logic signed [DATA_W-1:0] bin_re;
  logic signed [DATA_W-1:0] bin_im;
  logic [BIN_W-1:0]         bin_index;
  logic                     last_bin;

  spectrum_scoreboard spectrum;
  int                 idle_pct;
  int                 cycle_count = 0;

  q31_scaled_dft i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .log2_size_wr (log2_size_wr),
    .log2_size    (log2_size),
    .bin_valid    (bin_valid),
    .bin_re       (bin_re),
    .bin_im       (bin_im),
    .bin_index    (bin_index),
    .last_bin     (last_bin)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Bins cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    if (!rst && bin_valid) spectrum.check_bin(bin_re, bin_im, bin_index, last_bin);
  end

  function automatic logic signed [DATA_W-1:0] pick_q31();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        v = Q31_MAX;
      end
      1: begin
        v = Q31_MIN;
      end
      2: begin
        v = $urandom_range(4);
        v = v - 2;
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  // Start stays high between back-to-back transfers; it only drops for a gap.
  task automatic send_sample(input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    @(posedge clk);
    while (busy) @(posedge clk);
    spectrum.note_sample(re, im);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_sample(pick_q31(), pick_q31());
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (spectrum.pending_bins.size() != 0 || busy) @(posedge clk);
  endtask

  // A partial block leaves nothing to wait for, so a fixed pause covers any
  // transform still running before the length changes.
  task automatic write_length(input logic [LOG2_W-1:0] value);
    settle();
    repeat (80) @(posedge clk);
    @(negedge clk);
    log2_size_wr <= 1'b1;
    log2_size    <= value;
    @(negedge clk);
    log2_size_wr <= 1'b0;
    spectrum.set_length(value);
  endtask

  initial begin
    int unsigned phase;
    int unsigned pts;
    int unsigned sent;
    int unsigned k;
    logic [7:0]  re_high;
    logic [7:0]  im_high;

    start        = 1'b0;
    sample_re    = '0;
    sample_im    = '0;
    log2_size_wr = 1'b0;
    log2_size    = '0;
    rst          = 1'b1;
    idle_pct     = 0;
    spectrum     = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two points: opposite extremes, where the halved sum truncates to zero.
    write_length(3'd1);
    send_sample(Q31_MAX, Q31_MIN);
    send_sample(Q31_MIN, Q31_MAX);
    // Four points of full negative scale: bin 0 lands exactly on the Q31 minimum.
    write_length(3'd2);
    send_random(0);
    for (k = 0; k < 4; k++) send_sample(Q31_MIN, Q31_MIN);
    // A partial block is thrown away by rewriting the same length.
    write_length(3'd3);
    send_random(3);
    write_length(3'd3);
    // Eight points signed to follow bin 1's twiddle: saturates high, then low.
    re_high = 8'b1100_0111;
    im_high = 8'b0001_1111;
    for (k = 0; k < 8; k++) send_sample(re_high[k] ? Q31_MAX : Q31_MIN,
                                        im_high[k] ? Q31_MAX : Q31_MIN);
    for (k = 0; k < 8; k++) send_sample(re_high[k] ? Q31_MIN : Q31_MAX,
                                        im_high[k] ? Q31_MIN : Q31_MAX);

    for (phase = 0; phase < PHASES; phase++) begin
      write_length(PHASE_LENGTH[phase]);
      idle_pct = IDLE_MIX[phase % 4];
      pts      = 1 << spectrum.length_log2;
      sent     = 0;
      while (sent < 24) begin
        if ($urandom_range(9) == 0) settle();
        send_random(pts);
        sent += pts;
      end
      if ($urandom_range(2) == 0) send_random($urandom_range((pts > 6) ? 5 : pts - 1, 1));
    end

    settle();
    repeat (100) @(posedge clk);
    $display("Ran %0d transforms of 2 to 64 points with extremes, saturation and gaps;",
             spectrum.transforms);
    $display("%0d bins checked, %0d partial samples dropped, %0d mismatches.",
             spectrum.bins_seen, spectrum.discarded, spectrum.mismatches);
    if (spectrum.mismatches == 0 && spectrum.pending_bins.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/qsd_pkg.sv
rtl/core/qsd_ram.sv
rtl/core/q31_scaled_dft.sv
dv/testbench.sv
